FILE: rtl/camt_pkg.sv
`default_nettype none

package camt_pkg;

    localparam int unsigned CoordW   = 24;
    localparam int unsigned RadiusW  = 23;
    localparam int unsigned AngleW   = 19;
    localparam int unsigned AccW     = 33;
    localparam int unsigned CordicW  = 44;
    localparam int unsigned DefaultCordicSteps = 20;

    localparam logic signed [AccW-1:0]   HalfPiQ30 = 33'sd1686629713;
    localparam logic signed [AngleW-1:0] AngleMin  = -19'sd102944;
    localparam logic signed [AngleW-1:0] AngleMax  = 19'sd205888;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
        logic                     frame_end;
    } in_word_t;

    typedef struct packed {
        logic signed [AngleW-1:0] max_angle;
        logic signed [CoordW-1:0] contact_x;
        logic signed [CoordW-1:0] contact_y;
        logic signed [CoordW-1:0] contact_z;
        logic                     reused_previous;
        logic                     no_result;
    } out_word_t;

    // atan(2^-i) in Q2.30, rounded to nearest
    function automatic logic signed [AccW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [AccW-1:0] v;
        begin
            unique case (idx)
                5'd0:  v = 33'sd843314857;
                5'd1:  v = 33'sd497837829;
                5'd2:  v = 33'sd263043837;
                5'd3:  v = 33'sd133525159;
                5'd4:  v = 33'sd67021687;
                5'd5:  v = 33'sd33543516;
                5'd6:  v = 33'sd16775851;
                5'd7:  v = 33'sd8388437;
                5'd8:  v = 33'sd4194283;
                5'd9:  v = 33'sd2097149;
                5'd10: v = 33'sd1048576;
                5'd11: v = 33'sd524288;
                5'd12: v = 33'sd262144;
                5'd13: v = 33'sd131072;
                5'd14: v = 33'sd65536;
                5'd15: v = 33'sd32768;
                5'd16: v = 33'sd16384;
                5'd17: v = 33'sd8192;
                5'd18: v = 33'sd4096;
                5'd19: v = 33'sd2048;
                5'd20: v = 33'sd1024;
                5'd21: v = 33'sd512;
                5'd22: v = 33'sd256;
                5'd23: v = 33'sd128;
                5'd24: v = 33'sd64;
                5'd25: v = 33'sd32;
                5'd26: v = 33'sd16;
                5'd27: v = 33'sd8;
                5'd28: v = 33'sd4;
                5'd29: v = 33'sd2;
                5'd30: v = 33'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/contact_angle_max_tracker.sv
// Contact angle maximum tracker.
// Input channel (in_valid / in_stall / in_word) carries one contact point per
// word; frame_end marks the last point of a frame. Output channel (out_valid /
// out_stall / out_word) carries one result word per frame, issued after the
// last point. cfg_we / cfg_data write the body radius; write it only when idle.
// Each point with x >= 0 runs through one shared 24x24 multiplier, a radix-2
// square root and one shared CORDIC vectoring unit used twice; a point with
// negative x goes straight to the final state. The input is stalled while a
// point is in work, so a new point is taken only once the last one is done.
// A result waits in the output register; the next frame-ending point waits
// only if that word is still unread.
// Reset clears the radius, the frame best and the held result; the first
// empty frame after reset reports no_result with all other fields zero.
// A stalled output word holds until taken.
`default_nettype none

module contact_angle_max_tracker #(
    parameter int unsigned CORDIC_STEPS = camt_pkg::DefaultCordicSteps
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire camt_pkg::in_word_t                in_word,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output camt_pkg::out_word_t                    out_word,
    input  wire logic                              cfg_we,
    input  wire logic [camt_pkg::RadiusW-1:0]      cfg_data
);

    localparam int unsigned CW  = camt_pkg::CordicW;
    localparam int unsigned AW  = camt_pkg::AccW;
    localparam int unsigned SW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [SW-1:0] LastStep = SW'(CORDIC_STEPS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MXX  = 4'd1;
    localparam logic [3:0] S_MZZ  = 4'd2;
    localparam logic [3:0] S_MRR  = 4'd3;
    localparam logic [3:0] S_DIFF = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_COR1 = 4'd6;
    localparam logic [3:0] S_COR2 = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] state_reg, state_next;

    logic [camt_pkg::RadiusW-1:0] radius_reg;
    camt_pkg::in_word_t           pt_reg;

    // shared multiplier
    logic signed [23:0] mul_a, mul_b;
    logic signed [47:0] mul_p;
    logic [46:0]        prod_reg;
    logic [47:0]        d2_reg;
    logic               inside_reg;

    // square root
    logic [47:0] rad_reg;
    logic [26:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    logic [26:0] rem_sh, trial;

    // CORDIC
    logic signed [CW-1:0] ca_reg, cb_reg, ca_nx, cb_nx, da, db;
    logic signed [AW-1:0] acc_reg, acc_nx, a1_reg, a2_reg, a1_fix;
    logic [SW-1:0]        step_reg;

    // combine
    logic signed [AW+1:0]  ang_sum;
    logic signed [20:0]    ang_q;
    logic signed [camt_pkg::AngleW-1:0] ang_sat;

    // frame and held state
    logic signed [camt_pkg::AngleW-1:0] best_ang_reg, held_ang_reg;
    logic signed [camt_pkg::CoordW-1:0] best_x_reg, best_y_reg, best_z_reg;
    logic signed [camt_pkg::CoordW-1:0] held_x_reg, held_y_reg, held_z_reg;
    logic found_reg, held_valid_reg;

    logic out_valid_reg;
    camt_pkg::out_word_t out_word_reg;

    logic in_take, fin_go;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign fin_go    = !pt_reg.frame_end || !(out_valid_reg && out_stall);

    // select multiplier operands
    always_comb
    begin
        unique case (state_reg)
            S_MXX:
            begin
                mul_a = pt_reg.pos_x;
                mul_b = pt_reg.pos_x;
            end
            S_MZZ:
            begin
                mul_a = pt_reg.pos_z;
                mul_b = pt_reg.pos_z;
            end
            default:
            begin
                mul_a = {1'b0, radius_reg};
                mul_b = {1'b0, radius_reg};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // one radix-2 root digit
    always_comb
    begin
        rem_sh = {rem_reg[24:0], rad_reg[47:46]};
        trial  = {1'b0, root_reg, 2'b01};
    end

    // one CORDIC vectoring rotation
    always_comb
    begin
        da = cb_reg >>> step_reg;
        db = ca_reg >>> step_reg;
        if (!cb_reg[CW-1])
        begin
            ca_nx  = ca_reg + da;
            cb_nx  = cb_reg - db;
            acc_nx = acc_reg + camt_pkg::atan_entry(5'(step_reg));
        end
        else
        begin
            ca_nx  = ca_reg - da;
            cb_nx  = cb_reg + db;
            acc_nx = acc_reg - camt_pkg::atan_entry(5'(step_reg));
        end
    end

    // axis case of the first angle
    always_comb
    begin
        priority if (pt_reg.pos_x != '0)
            a1_fix = acc_nx;
        else if (pt_reg.pos_z[camt_pkg::CoordW-1])
            a1_fix = -camt_pkg::HalfPiQ30;
        else if (pt_reg.pos_z != '0)
            a1_fix = camt_pkg::HalfPiQ30;
        else
            a1_fix = '0;
    end

    // round to Q16 and saturate
    always_comb
    begin
        ang_sum = (AW+2)'(a1_reg) + (AW+2)'(a2_reg) + (AW+2)'(8192);
        ang_q   = ang_sum[AW+1:14];
        priority if (ang_q < 21'(camt_pkg::AngleMin))
            ang_sat = camt_pkg::AngleMin;
        else if (ang_q > 21'(camt_pkg::AngleMax))
            ang_sat = camt_pkg::AngleMax;
        else
            ang_sat = ang_q[camt_pkg::AngleW-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_take)
                    state_next = in_word.pos_x[camt_pkg::CoordW-1] ? S_FIN : S_MXX;
            S_MXX:  state_next = S_MZZ;
            S_MZZ:  state_next = S_MRR;
            S_MRR:  state_next = S_DIFF;
            S_DIFF: state_next = S_SQRT;
            S_SQRT: if (sq_cnt_reg == 5'd23) state_next = S_COR1;
            S_COR1: if (step_reg == LastStep) state_next = S_COR2;
            S_COR2: if (step_reg == LastStep) state_next = S_SUM;
            S_SUM:  state_next = S_FIN;
            S_FIN:  if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            radius_reg     <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            best_ang_reg   <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
            best_z_reg     <= '0;
            held_ang_reg   <= '0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_z_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                radius_reg <= cfg_data;

            // load a new output word, or drop the current one once taken
            if (state_reg == S_FIN && pt_reg.frame_end && fin_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // keep the first point reaching the largest angle
            if (state_reg == S_SUM && (!found_reg || ang_sat > best_ang_reg))
            begin
                best_ang_reg <= ang_sat;
                best_x_reg   <= pt_reg.pos_x;
                best_y_reg   <= pt_reg.pos_y;
                best_z_reg   <= pt_reg.pos_z;
                found_reg    <= 1'b1;
            end

            // close the frame
            if (state_reg == S_FIN && pt_reg.frame_end && fin_go)
            begin
                if (found_reg)
                begin
                    held_ang_reg   <= best_ang_reg;
                    held_x_reg     <= best_x_reg;
                    held_y_reg     <= best_y_reg;
                    held_z_reg     <= best_z_reg;
                    held_valid_reg <= 1'b1;
                end
                found_reg    <= 1'b0;
                best_ang_reg <= '0;
                best_x_reg   <= '0;
                best_y_reg   <= '0;
                best_z_reg   <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            pt_reg <= in_word;

        prod_reg <= mul_p[46:0];
        if (state_reg == S_MZZ)
            d2_reg <= {1'b0, prod_reg};
        if (state_reg == S_MRR)
            d2_reg <= d2_reg + {1'b0, prod_reg};

        // start the root on d2 - R^2
        if (state_reg == S_DIFF)
        begin
            inside_reg <= (d2_reg <= {1'b0, prod_reg});
            rad_reg    <= d2_reg - {1'b0, prod_reg};
            rem_reg    <= '0;
            root_reg   <= '0;
            sq_cnt_reg <= '0;
        end

        if (state_reg == S_SQRT)
        begin
            rad_reg    <= {rad_reg[45:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + 5'd1;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[22:0], 1'b0};
            end
            // load the first vector (x, z)
            if (sq_cnt_reg == 5'd23)
            begin
                ca_reg   <= CW'($signed({pt_reg.pos_x, 16'b0}));
                cb_reg   <= CW'($signed({pt_reg.pos_z, 16'b0}));
                acc_reg  <= '0;
                step_reg <= '0;
            end
        end

        if (state_reg == S_COR1 || state_reg == S_COR2)
        begin
            if (step_reg == LastStep)
            begin
                step_reg <= '0;
                acc_reg  <= '0;
                if (state_reg == S_COR1)
                begin
                    // load the second vector (w, R)
                    a1_reg <= a1_fix;
                    ca_reg <= CW'({root_reg, 16'b0});
                    cb_reg <= CW'({radius_reg, 16'b0});
                end
                else
                    a2_reg <= inside_reg ? camt_pkg::HalfPiQ30 : acc_nx;
            end
            else
            begin
                ca_reg   <= ca_nx;
                cb_reg   <= cb_nx;
                acc_reg  <= acc_nx;
                step_reg <= step_reg + SW'(1);
            end
        end

        // build the result word
        if (state_reg == S_FIN && pt_reg.frame_end && fin_go)
        begin
            if (found_reg)
            begin
                out_word_reg.max_angle       <= best_ang_reg;
                out_word_reg.contact_x       <= best_x_reg;
                out_word_reg.contact_y       <= best_y_reg;
                out_word_reg.contact_z       <= best_z_reg;
                out_word_reg.reused_previous <= 1'b0;
                out_word_reg.no_result       <= 1'b0;
            end
            else
            begin
                out_word_reg.max_angle       <= held_ang_reg;
                out_word_reg.contact_x       <= held_x_reg;
                out_word_reg.contact_y       <= held_y_reg;
                out_word_reg.contact_z       <= held_z_reg;
                out_word_reg.reused_previous <= held_valid_reg;
                out_word_reg.no_result       <= !held_valid_reg;
            end
        end
    end

    // a new result word only follows a frame close
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_FIN)
        else $error("result word without frame close");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_word.no_result && out_word.reused_previous))
        else $error("both result flags set");

    a_no_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.no_result) |->
            (out_word.max_angle == '0 && out_word.contact_x == '0))
        else $error("no_result word not zero");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.max_angle >= camt_pkg::AngleMin &&
                       out_word.max_angle <= camt_pkg::AngleMax))
        else $error("angle out of range");

endmodule

`default_nettype wire

FILE: tb/contact_angle_max_tracker_tb.sv
`default_nettype none

module contact_angle_max_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Steps = camt_pkg::DefaultCordicSteps;
    localparam int IdleLimit = 6000;
    localparam longint HalfPi = 1686629713;
    localparam longint AtanQ30 [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    camt_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    camt_pkg::out_word_t out_word;
    logic cfg_we = 1'b0;
    logic [camt_pkg::RadiusW-1:0] cfg_data = '0;

    // predictor state
    longint unsigned radius = 0;
    logic signed [camt_pkg::AngleW-1:0] best_angle = '0;
    camt_pkg::in_word_t best_point = '0;
    bit best_found = 1'b0;
    logic signed [camt_pkg::AngleW-1:0] held_angle = '0;
    camt_pkg::in_word_t held_point = '0;
    bit held_ok = 1'b0;

    camt_pkg::out_word_t frame_results [$];
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    int stall_run = 0;

    contact_angle_max_tracker uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // atan2(b, a) for a > 0 by CORDIC vectoring, Q2.30
    function automatic longint vector_angle(longint a, longint b);
        longint acc;
        longint da;
        longint db;
        acc = 0;
        for (int i = 0; i < Steps; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0)
            begin
                a = a + da;
                b = b - db;
                acc = acc + AtanQ30[i];
            end
            else
            begin
                a = a - da;
                b = b + db;
                acc = acc - AtanQ30[i];
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [camt_pkg::AngleW-1:0] contact_angle(longint x,
                                                                        longint z);
        longint a1;
        longint a2;
        longint q;
        longint unsigned d2;
        longint unsigned r2;
        d2 = x * x + z * z;
        r2 = radius * radius;
        if (x == 0)
            a1 = (z > 0) ? HalfPi : ((z < 0) ? -HalfPi : 0);
        else
            a1 = vector_angle(x * 65536, z * 65536);
        if (d2 <= r2)
            a2 = HalfPi;
        else
            a2 = vector_angle(longint'(int_sqrt(d2 - r2)) * 65536, longint'(radius) * 65536);
        q = (a1 + a2 + 8192) >>> 14;
        if (q < -102944)
            q = -102944;
        if (q > 205888)
            q = 205888;
        return q[camt_pkg::AngleW-1:0];
    endfunction

    // advance the tracker by one point; queue a result on frame end
    task automatic track_point(camt_pkg::in_word_t p);
        logic signed [camt_pkg::AngleW-1:0] ang;
        camt_pkg::out_word_t r;
        longint x;
        x = $signed(p.pos_x);
        if (x >= 0)
        begin
            ang = contact_angle(x, $signed(p.pos_z));
            if (!best_found || ang > best_angle)
            begin
                best_angle = ang;
                best_point = p;
                best_found = 1'b1;
            end
        end
        if (p.frame_end)
        begin
            r = '0;
            if (best_found)
            begin
                held_angle = best_angle;
                held_point = best_point;
                held_ok = 1'b1;
            end
            else if (held_ok)
                r.reused_previous = 1'b1;
            else
                r.no_result = 1'b1;
            r.max_angle = held_angle;
            r.contact_x = held_point.pos_x;
            r.contact_y = held_point.pos_y;
            r.contact_z = held_point.pos_z;
            frame_results = {frame_results, r};
            best_found = 1'b0;
            best_angle = '0;
            best_point = '0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one word; called at a rising edge
    task automatic send_point(longint x, longint y, longint z, bit last);
        camt_pkg::in_word_t w;
        int gap;
        w.pos_x = x[camt_pkg::CoordW-1:0];
        w.pos_y = y[camt_pkg::CoordW-1:0];
        w.pos_z = z[camt_pkg::CoordW-1:0];
        w.frame_end = last;
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (in_stall);
        track_point(w);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (2 * 32 + 60) @(posedge clk);
    endtask

    task automatic set_radius(longint unsigned r);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= r[camt_pkg::RadiusW-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        radius = r;
    endtask

    function automatic longint rand_coord();
        return $signed(24'($urandom));
    endfunction

    function automatic longint small_coord();
        return $signed(24'($urandom_range(0, 2 ** 20))) - 24'sd524288;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin
        camt_pkg::out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_results.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                e = frame_results.pop_front();
                if (out_word.max_angle !== e.max_angle)
                    report("max_angle", out_word.max_angle, e.max_angle);
                if (out_word.contact_x !== e.contact_x)
                    report("contact_x", out_word.contact_x, e.contact_x);
                if (out_word.contact_y !== e.contact_y)
                    report("contact_y", out_word.contact_y, e.contact_y);
                if (out_word.contact_z !== e.contact_z)
                    report("contact_z", out_word.contact_z, e.contact_z);
                if (out_word.reused_previous !== e.reused_previous)
                    report("reused_previous", out_word.reused_previous, e.reused_previous);
                if (out_word.no_result !== e.no_result)
                    report("no_result", out_word.no_result, e.no_result);
            end
        end
    end

    // random back-pressure with occasional long holds
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else if (r < 4)
        begin
            stall_run <= $urandom_range(10, 50);
            out_stall <= 1'b1;
        end
        else
            out_stall <= (r < 30);
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("** contact_angle_max_tracker: FAILED **");
            $finish;
        end
    end

    task automatic test_empty_start();
        send_point(-5, 7, 9, 1'b1);
        send_point(-1, 0, 0, 1'b0);
        send_point(-8388608, 8388607, -8388608, 1'b1);
    endtask

    task automatic test_special_points();
        // zero x with positive, negative and zero z
        send_point(0, 1, 65536, 1'b1);
        send_point(0, 2, -65536, 1'b1);
        send_point(0, 3, 0, 1'b1);
        // extremes of the fields
        send_point(8388607, 8388607, 8388607, 1'b0);
        send_point(8388607, -8388608, -8388608, 1'b1);
        send_point(1, -1, -8388608, 1'b1);
        // equal angles keep the earlier point
        send_point(70000, 11, 30000, 1'b0);
        send_point(70000, 22, 30000, 1'b1);
        // empty frame after a result
        send_point(-70000, 5, 5, 1'b1);
    endtask

    task automatic test_radius_extremes();
        set_radius(65536);
        send_point(30000, 1, 20000, 1'b0);
        send_point(65536, 2, 0, 1'b0);
        send_point(200000, 3, -100000, 1'b1);
        set_radius(8388607);
        send_point(8388607, 4, 0, 1'b0);
        send_point(8388607, 5, 8388607, 1'b1);
        send_point(0, 6, -8388608, 1'b1);
        set_radius(0);
        send_point(123456, 7, -654321, 1'b1);
    endtask

    task automatic random_frames(int points);
        int n;
        int len;
        longint x;
        n = 0;
        while (n < points)
        begin
            if (n % 90 == 0)
                calm = ($urandom_range(0, 3) == 0);
            len = $urandom_range(0, 9) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 1))
                    x = small_coord();
                else
                    x = rand_coord();
                if ($urandom_range(0, 3) == 0)
                    x = -(x < 0 ? -x : x) - 1;
                else if (x < 0)
                    x = -x - 1;
                if ($urandom_range(0, 19) == 0)
                    x = 0;
                send_point(x, rand_coord(),
                    $urandom_range(0, 1) ? small_coord() : rand_coord(), k == len - 1);
                n++;
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_random();
        random_frames(300);
        set_radius($urandom_range(1, 200000));
        random_frames(300);
        set_radius(8388607);
        random_frames(150);
        set_radius($urandom_range(0, 8388607));
        random_frames(300);
        set_radius($urandom_range(0, 40000));
        random_frames(300);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_start();
        test_special_points();
        test_radius_extremes();
        test_random();
        wait_idle();
        if (frame_results.size() != 0)
            report("missing words", 0, frame_results.size());
        if (errors == 0)
            $display("** contact_angle_max_tracker: PASSED **");
        else
            $display("** contact_angle_max_tracker: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
